// ===== sv/iirdf1_pkg.sv =====
`default_nettype none
package iirdf1_pkg;

   // sample and coefficient formats
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 24;
   localparam int FRAC_W   = 20;
   localparam int HIST_W   = 40;                 // stored output history, Q19.20
   localparam int HALF_W   = HIST_W / 2;         // history split for the multiplier
   localparam int MDATA_W  = HALF_W + 1;         // signed data operand of the multiplier
   localparam int PROD_W   = COEF_W + MDATA_W;
   localparam int ACC_W    = 48;
   localparam int CSR_IDX_W = 8;

   // register map: feedforward b[0..4], then feedback a[1..3]
   localparam int NB_MAX   = 5;
   localparam int NA_MAX   = 3;
   localparam int NUM_COEF = NB_MAX + NA_MAX;

   localparam logic [COEF_W-1:0] COEF_ONE = 24'h10_0000;   // 1.0 in Q3.20

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SAT   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      KIND_FF    = 2'd0,   // b*x, added
      KIND_FB_LO = 2'd1,   // a*y low half, rounded, subtracted
      KIND_FB_HI = 2'd2    // a*y high half, subtracted
   } kind_type;

endpackage
`default_nettype wire

// ===== sv/iir_direct_form_one_filter.sv =====
`default_nettype none
// Direct form I IIR filter for signed 16-bit samples. Each req item carries one
// sample x(n); one rsp item comes back with y(n) = sum b[k]*x(n-k) - sum a[k]*y(n-k),
// rounded half away from zero and saturated to 16 bits, plus a clip flag in tuser.
// Coefficients are signed Q3.20 registers written over the csr port (index 0..4:
// b[0..4], index 5..7: a[1..3]; other indexes are dropped). After reset b[0] = 1.0
// and all others are zero, so the block passes samples through. Output history is
// kept unrounded with 20 fractional bits and saturated to 40 bits. All products go
// through one shared 24x21 signed multiplier: one product per feedforward tap and two
// per feedback tap (low and high half of the 40-bit history). req_tready is low from
// the accept until the result is in the rsp register, so a new item is taken only
// once the previous one is finished. A finished result sits in the rsp register, so
// the next item can be taken before the previous result is read; the filter only
// waits if that earlier result is still unread when the next one is done.
module iir_direct_form_one_filter #(
   parameter int NUM_TAPS = 5,   // feedforward taps, 1..5
   parameter int FB_TAPS  = 4    // feedback taps including a[0], 1..4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // input items
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [iirdf1_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] sample
   // result items
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [iirdf1_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] filtered
   output logic                                  rsp_tuser,   // [0] clipped
   // coefficient writes
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [iirdf1_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [iirdf1_pkg::COEF_W-1:0]         csr_wdata
);
   import iirdf1_pkg::*;

   localparam int N_OPS    = NUM_TAPS + 2 * (FB_TAPS - 1);
   localparam int OP_W     = $clog2(N_OPS + 1);
   localparam int XH_DEPTH = (NUM_TAPS > 1) ? NUM_TAPS - 1 : 1;
   localparam int YH_DEPTH = (FB_TAPS > 1) ? FB_TAPS - 1 : 1;
   localparam logic [ACC_W-1:0] HIST_MAX = ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
   localparam logic [ACC_W-1:0] HIST_MIN = ACC_W'(-(64'sd1 <<< (HIST_W - 1)));

   state_type                     state_ff, state_in;
   logic [OP_W-1:0]               idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0]    sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0]    xh_ff [XH_DEPTH];
   logic signed [HIST_W-1:0]      yh_ff [YH_DEPTH];
   logic signed [COEF_W-1:0]      coef_ff [NUM_COEF];
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   kind_type                      kind_ff, kind_in;
   logic                          prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [SAMPLE_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   logic                          req_acc, out_free, hist_upd;
   logic [OP_W-1:0]               rel, fb_sel;
   logic signed [COEF_W-1:0]      mul_a;
   logic signed [MDATA_W-1:0]     mul_b;
   logic signed [ACC_W-1:0]       term;
   logic signed [PROD_W:0]        lo_sum;
   logic signed [ACC_W-1:0]       acc_sat;
   logic                          neg;
   logic [HIST_W:0]               mag;
   logic [HIST_W:0]               mag_rnd;
   logic [HIST_W-FRAC_W:0]        q;
   logic                          clip;
   logic [SAMPLE_W-1:0]           q_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;
   assign hist_upd   = (state_ff == ST_SAT);

   // operand select for the shared multiplier
   always_comb begin
      rel    = idx_ff - OP_W'(NUM_TAPS);
      fb_sel = rel >> 1;
      mul_a  = '0;
      mul_b  = '0;
      if (idx_ff < OP_W'(NUM_TAPS)) begin
         kind_in = KIND_FF;
         if (idx_ff == '0) begin
            mul_b = MDATA_W'(sample_ff);
         end
         for (int k = 0; k < NUM_TAPS; k++) begin
            if (idx_ff == OP_W'(k)) begin
               mul_a = coef_ff[k];
            end
         end
         for (int k = 0; k < NUM_TAPS - 1; k++) begin
            if (idx_ff == OP_W'(k + 1)) begin
               mul_b = MDATA_W'(xh_ff[k]);
            end
         end
      end else begin
         kind_in = rel[0] ? KIND_FB_HI : KIND_FB_LO;
         for (int k = 0; k < FB_TAPS - 1; k++) begin
            if (fb_sel == OP_W'(k)) begin
               mul_a = coef_ff[NB_MAX + k];
               // high half is signed, low half is a plain magnitude
               mul_b = rel[0] ? MDATA_W'($signed(yh_ff[k][HIST_W-1:HALF_W]))
                              : $signed({1'b0, yh_ff[k][HALF_W-1:0]});
            end
         end
      end
      prod_in     = mul_a * mul_b;
      prod_vld_in = (state_ff == ST_RUN);
   end

   // accumulate the registered product
   always_comb begin
      lo_sum = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(1 <<< (FRAC_W - 1));
      if (kind_ff == KIND_FB_LO) begin
         term = ACC_W'(lo_sum >>> FRAC_W);
      end else begin
         term = ACC_W'(prod_ff);
      end
   end

   // 40-bit history clamp, then round half away from zero and clamp to 16 bits
   always_comb begin
      if (!acc_ff[ACC_W-1] && acc_ff > $signed(HIST_MAX)) begin
         acc_sat = $signed(HIST_MAX);
      end else if (acc_ff[ACC_W-1] && acc_ff < $signed(HIST_MIN)) begin
         acc_sat = $signed(HIST_MIN);
      end else begin
         acc_sat = acc_ff;
      end
      neg     = acc_ff[ACC_W-1];
      mag     = neg ? (HIST_W + 1)'(-acc_ff) : (HIST_W + 1)'(acc_ff);
      mag_rnd = mag + (HIST_W + 1)'(1 <<< (FRAC_W - 1));
      q       = mag_rnd[HIST_W:FRAC_W];
      q_val   = q[SAMPLE_W-1:0];
      if (neg) begin
         clip = (q > (HIST_W - FRAC_W + 1)'(32768));
      end else begin
         clip = (q > (HIST_W - FRAC_W + 1)'(32767));
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      sample_in   = sample_ff;
      acc_in      = acc_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_clip_in = rsp_clip_ff;
      if (prod_vld_ff) begin
         acc_in = (kind_ff == KIND_FF) ? acc_ff + term : acc_ff - term;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sample_in = req_tdata;
               idx_in    = '0;
               acc_in    = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            idx_in = idx_ff + OP_W'(1);
            if (idx_ff == OP_W'(N_OPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            acc_in   = acc_sat;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_clip_in = clip;
               if (clip) begin
                  rsp_data_in = neg ? 16'h8000 : 16'h7FFF;
               end else begin
                  rsp_data_in = neg ? -q_val : q_val;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      kind_ff     <= kind_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEF; k++) begin
            coef_ff[k] <= (k == 0) ? COEF_ONE : '0;
         end
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_COEF)) begin
         coef_ff[csr_index[$clog2(NUM_COEF)-1:0]] <= csr_wdata;
      end
   end

   // input history: x(n-1) at slot 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < XH_DEPTH; k++) begin
            xh_ff[k] <= '0;
         end
      end else if (hist_upd && NUM_TAPS > 1) begin
         xh_ff[0] <= sample_ff;
         for (int k = 1; k < XH_DEPTH; k++) begin
            xh_ff[k] <= xh_ff[k-1];
         end
      end
   end

   // output history: y(n-1) at slot 0, left alone without feedback taps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < YH_DEPTH; k++) begin
            yh_ff[k] <= '0;
         end
      end else if (hist_upd && FB_TAPS > 1) begin
         yh_ff[0] <= acc_sat[HIST_W-1:0];
         for (int k = 1; k < YH_DEPTH; k++) begin
            yh_ff[k] <= yh_ff[k-1];
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/iirdf1_check.sv =====
`default_nettype none
module iirdf1_check (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tuser
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // req_tready stays low after an accept while the shared unit is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("req accepted while filter busy");

   // clipped results sit at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000))
      else $error("clip flag without rail value");

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind iir_direct_form_one_filter iirdf1_check u_iirdf1_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== verif/iir_direct_form_one_filter_checker.sv =====
`timescale 1ns / 100ps
module iir_direct_form_one_filter_checker #(
   parameter int NUM_TAPS = 5,
   parameter int FB_TAPS  = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   input  wire                                  req_tready,
   input  wire  [iirdf1_pkg::SAMPLE_W-1:0]      req_tdata,
   input  wire                                  rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire  [iirdf1_pkg::SAMPLE_W-1:0]      rsp_tdata,
   input  wire                                  rsp_tuser,
   input  wire                                  csr_valid,
   input  wire                                  csr_ready,
   input  wire  [iirdf1_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [iirdf1_pkg::COEF_W-1:0]        csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   results_checked,
   output int                                   clips_seen
);
   import iirdf1_pkg::*;

   localparam longint HIST_MAX = (longint'(1) <<< (HIST_W - 1)) - 1;
   localparam longint HIST_MIN = -(longint'(1) <<< (HIST_W - 1));
   localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);
   localparam longint OUT_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint OUT_MIN  = -(longint'(1) <<< (SAMPLE_W - 1));

   typedef struct packed {
      logic [SAMPLE_W-1:0] filtered;
      logic                clipped;
   } filt_out_type;

   logic signed [COEF_W-1:0]   ff_coef [NB_MAX];
   logic signed [COEF_W-1:0]   fb_coef [NA_MAX];
   logic signed [SAMPLE_W-1:0] x_hist  [NB_MAX-1];
   longint                     y_hist  [NA_MAX];   // unrounded, FRAC_W fraction bits
   filt_out_type               filtered_due [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // one direct form I step; updates the input history and, with feedback taps, the output history
   function automatic filt_out_type filter_sample(input logic signed [SAMPLE_W-1:0] x);
      longint       acc;
      longint       rounded;
      filt_out_type res;
      int           k;
      acc = longint'(ff_coef[0]) * longint'(x);
      for (k = 1; k < NUM_TAPS && k < NB_MAX; k++)
         acc += longint'(ff_coef[k]) * longint'(x_hist[k-1]);
      for (k = NUM_TAPS - 1; k > 0; k--)
         if (k < NB_MAX - 1) x_hist[k] = x_hist[k-1];
      x_hist[0] = x;
      // feedback products rounded to FRAC_W bits (add half, floor)
      if (FB_TAPS > 1)
         for (k = 1; k < FB_TAPS && k <= NA_MAX; k++)
            acc -= (longint'(fb_coef[k-1]) * y_hist[k-1] + HALF_LSB) >>> FRAC_W;
      if (acc > HIST_MAX) acc = HIST_MAX;
      if (acc < HIST_MIN) acc = HIST_MIN;
      if (FB_TAPS > 1) begin
         for (k = FB_TAPS - 1; k > 0; k--)
            if (k < NA_MAX) y_hist[k] = y_hist[k-1];
         y_hist[0] = acc;
      end
      // half away from zero
      if (acc >= 0)
         rounded = (acc + HALF_LSB) >>> FRAC_W;
      else
         rounded = -((-acc + HALF_LSB) >>> FRAC_W);
      res.clipped = 1'b0;
      if (rounded > OUT_MAX) begin
         rounded = OUT_MAX;
         res.clipped = 1'b1;
      end
      if (rounded < OUT_MIN) begin
         rounded = OUT_MIN;
         res.clipped = 1'b1;
      end
      res.filtered = rounded[SAMPLE_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      filt_out_type want;
      if (reset) begin
         ff_coef[0] = COEF_ONE;
         for (int i = 1; i < NB_MAX; i++) ff_coef[i] = '0;
         for (int i = 0; i < NA_MAX; i++) fb_coef[i] = '0;
         for (int i = 0; i < NB_MAX - 1; i++) x_hist[i] = '0;
         for (int i = 0; i < NA_MAX; i++) y_hist[i] = 0;
         filtered_due.delete();
         mismatches      = 0;
         results_checked = 0;
         clips_seen      = 0;
      end else begin
         // a result can't belong to an item taken on this same edge, so pop first
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_due.size() == 0) begin
               report_mismatch("result with no sample waiting", signed'(rsp_tdata), 0);
            end else begin
               want = filtered_due.pop_front();
               if (rsp_tdata !== want.filtered)
                  report_mismatch("filtered", signed'(rsp_tdata), signed'(want.filtered));
               if (rsp_tuser !== want.clipped)
                  report_mismatch("clipped", rsp_tuser, want.clipped);
               results_checked++;
               if (want.clipped) clips_seen++;
            end
         end
         if (req_tvalid && req_tready)
            filtered_due.push_back(filter_sample(req_tdata));
         if (csr_valid && csr_ready) begin
            if (csr_index < NB_MAX)
               ff_coef[csr_index] = csr_wdata;
            else if (csr_index < NUM_COEF)
               fb_coef[csr_index - NB_MAX] = csr_wdata;
         end
      end
      outstanding <= filtered_due.size();
   end

endmodule

// ===== verif/iir_direct_form_one_filter_tb.sv =====
`timescale 1ns / 100ps
module iir_direct_form_one_filter_tb;
   import iirdf1_pkg::*;

   localparam int NUM_TAPS        = 5;
   localparam int FB_TAPS         = 4;
   localparam int N_RANDOM_SETS   = 9;
   localparam int SAMPLES_PER_SET = 100;
   localparam int STEADY_SET      = 4;     // this set runs with no idling on either side
   localparam int IDLE_PCT        = 14;
   localparam int DRAIN_CYCLES    = 32;    // settle time after each burst's last result

   // coefficient register map
   localparam logic [CSR_IDX_W-1:0] REG_NUM_0        = 0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_1        = 1;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_2        = 2;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_3        = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_4        = 4;
   localparam logic [CSR_IDX_W-1:0] REG_FB_1         = 5;
   localparam logic [CSR_IDX_W-1:0] REG_FB_2         = 6;
   localparam logic [CSR_IDX_W-1:0] REG_FB_3         = 7;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = CSR_IDX_W'(NUM_COEF);
   localparam logic [CSR_IDX_W-1:0] REG_LAST_UNUSED  = '1;

   localparam logic [COEF_W-1:0]   COEF_MAX   = 24'h7F_FFFF;   // just under +8.0
   localparam logic [COEF_W-1:0]   COEF_MIN   = 24'h80_0000;   // -8.0
   localparam logic [COEF_W-1:0]   COEF_HALF  = 24'h08_0000;   // 0.5
   localparam int                  ONE_Q20    = 1 << FRAC_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [COEF_W-1:0]    csr_wdata  = '0;

   logic steady = 1'b0;   // high: no gaps from the sender, no stalls from the receiver
   int   mismatches;
   int   outstanding;
   int   results_checked;
   int   clips_seen;
   int   samples_sent = 0;
   int   coef_sets    = 0;

   iir_direct_form_one_filter #(
      .NUM_TAPS(NUM_TAPS),
      .FB_TAPS (FB_TAPS)
   ) uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   iir_direct_form_one_filter_checker #(
      .NUM_TAPS(NUM_TAPS),
      .FB_TAPS (FB_TAPS)
   ) watch (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .mismatches, .outstanding, .results_checked, .clips_seen
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, none during the steady stretch
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

   // Hard stop, several times longer than the slowest legal run with its gaps
   // and stalls.
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // one register write; csr_valid stays up so back-to-back writes need no re-raise
   task automatic load_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // full coefficient set plus one write to an unmapped index, which must be dropped
   task automatic load_coef_set(
      input logic [COEF_W-1:0]    b0, b1, b2, b3, b4,
      input logic [COEF_W-1:0]    a1, a2, a3,
      input logic [CSR_IDX_W-1:0] unused_idx,
      input logic [COEF_W-1:0]    unused_data
   );
      load_coef(REG_NUM_0, b0);
      load_coef(REG_NUM_1, b1);
      load_coef(REG_NUM_2, b2);
      load_coef(REG_NUM_3, b3);
      load_coef(REG_NUM_4, b4);
      load_coef(REG_FB_1, a1);
      load_coef(REG_FB_2, a2);
      load_coef(REG_FB_3, a3);
      load_coef(unused_idx, unused_data);
      csr_valid <= 1'b0;
      coef_sets++;
   endtask

   // offer one sample, maybe after a random gap; tvalid is only dropped for a gap
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      if (!steady)
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // close a burst and wait until every result is back, then let the block settle
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);   // outstanding is registered and trails the last accept
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly full-range noise, some rail values, some small ECG-sized swings
   function automatic logic [SAMPLE_W-1:0] random_sample();
      int          pick;
      int          v;
      logic [31:0] r;
      pick = $urandom_range(0, 99);
      r    = $urandom;
      v    = int'($urandom_range(0, 1023)) - 512;
      if (pick < 55) return r[SAMPLE_W-1:0];
      if (pick < 70) begin
         case (r[1:0])
            2'd0:    return SAMPLE_MAX;
            2'd1:    return SAMPLE_MIN;
            2'd2:    return '0;
            default: return '1;
         endcase
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // feedforward: mostly within +-1.0, with full range, rails and zero mixed in
   function automatic logic [COEF_W-1:0] random_ff_coef();
      int          pick;
      int          v;
      logic [31:0] r;
      pick = $urandom_range(0, 99);
      r    = $urandom;
      v    = int'($urandom_range(0, 2 * ONE_Q20)) - ONE_Q20;
      if (pick < 50) return v[COEF_W-1:0];
      if (pick < 70) return r[COEF_W-1:0];
      if (pick < 85) return r[0] ? COEF_MAX : COEF_MIN;
      return '0;
   endfunction

   // feedback: often zero or small (stable-ish), sometimes anything
   function automatic logic [COEF_W-1:0] random_fb_coef();
      int          pick;
      int          v;
      logic [31:0] r;
      pick = $urandom_range(0, 99);
      r    = $urandom;
      v    = int'($urandom_range(0, ONE_Q20 / 2)) - ONE_Q20 / 4;
      if (pick < 40) return '0;
      if (pick < 75) return v[COEF_W-1:0];
      if (pick < 90) return r[COEF_W-1:0];
      return r[0] ? COEF_MAX : COEF_MIN;
   endfunction

   initial begin
      int set;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: straight pass-through, sample rails
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample('0);
      push_sample('1);
      push_sample(16'h0001);
      finish_burst();

      // all feedforward taps at max: clipping, then the 40-bit history limit
      load_coef(REG_LAST_UNUSED, COEF_MAX);
      load_coef_set(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, '0, '0, '0,
                    REG_FIRST_UNUSED, COEF_MIN);
      repeat (4) push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      finish_burst();

      // gain of one half: exact halves round away from zero
      load_coef_set(COEF_HALF, '0, '0, '0, '0, '0, '0, '0, REG_FIRST_UNUSED, '1);
      push_sample(16'h0001);
      push_sample(16'hFFFF);
      push_sample(16'h0003);
      push_sample(16'hFFFD);
      finish_burst();

      // a[1] = -8: y grows eightfold each step until the history saturates
      load_coef_set(COEF_ONE, '0, '0, '0, '0, COEF_MIN, '0, '0, REG_LAST_UNUSED, '0);
      push_sample(SAMPLE_MAX);
      repeat (4) push_sample('0);
      finish_burst();

      // feedforward at -8, feedback at both rails: negative history saturation
      load_coef_set(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                    COEF_MAX, COEF_MIN, COEF_MAX, REG_FIRST_UNUSED, COEF_MAX);
      repeat (3) push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      finish_burst();

      // random coefficient sets, first one pure FIR, one with no idling at all
      for (set = 0; set < N_RANDOM_SETS; set++) begin
         steady = (set == STEADY_SET);
         load_coef_set(random_ff_coef(), random_ff_coef(), random_ff_coef(),
                       random_ff_coef(), random_ff_coef(),
                       (set == 0) ? '0 : random_fb_coef(),
                       (set == 0) ? '0 : random_fb_coef(),
                       (set == 0) ? '0 : random_fb_coef(),
                       CSR_IDX_W'($urandom_range(NUM_COEF, (1 << CSR_IDX_W) - 1)),
                       COEF_W'($urandom));
         for (n = 0; n < SAMPLES_PER_SET; n++) push_sample(random_sample());
         finish_burst();
      end
      steady = 1'b0;

      $display("summary: %0d samples over %0d coefficient sets, %0d results checked",
               samples_sent, coef_sets, results_checked);
      $display("summary: %0d clipped results, %0d mismatches", clips_seen, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/iirdf1_pkg.sv
sv/iir_direct_form_one_filter.sv
sv/iirdf1_check.sv
verif/iir_direct_form_one_filter_checker.sv
verif/iir_direct_form_one_filter_tb.sv
